// File: src/ddp_pkg.sv
package ddp_pkg;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_MUL  = 11'b000_0000_0010,
		ST_WB   = 11'b000_0000_0100,
		ST_SCI  = 11'b000_0000_1000,
		ST_ROT  = 11'b000_0001_0000,
		ST_SCD  = 11'b000_0010_0000,
		ST_CENT = 11'b000_0100_0000,
		ST_VECD = 11'b000_1000_0000,
		ST_PXI  = 11'b001_0000_0000,
		ST_PXD  = 11'b010_0000_0000,
		ST_OUT  = 11'b100_0000_0000
	} state_t;

	// multiplier micro-steps: operand pair and destination
	localparam logic [3:0] MS_TAU_SPD = 4'd0;
	localparam logic [3:0] MS_DUTY_L  = 4'd1;
	localparam logic [3:0] MS_DUTY_R  = 4'd2;
	localparam logic [3:0] MS_HW_S    = 4'd3;
	localparam logic [3:0] MS_HW_C    = 4'd4;
	localparam logic [3:0] MS_D1_C    = 4'd5;
	localparam logic [3:0] MS_D1_S    = 4'd6;
	localparam logic [3:0] MS_D2_C    = 4'd7;
	localparam logic [3:0] MS_D2_S    = 4'd8;
	localparam logic [3:0] MS_SX      = 4'd9;
	localparam logic [3:0] MS_SY      = 4'd10;
	localparam logic [3:0] MS_FX      = 4'd11;
	localparam logic [3:0] MS_FY      = 4'd12;

	localparam logic [1:0] REG_HALF_TRACK   = 2'd0;
	localparam logic [1:0] REG_HALF_LENGTH  = 2'd1;
	localparam logic [1:0] REG_SPEED        = 2'd2;
	localparam logic [1:0] REG_ARENA        = 2'd3;

	localparam logic [31:0] CORDIC_GAIN  = 32'h26DD_3B6A;
	localparam logic [31:0] TURN_HALF    = 32'h8000_0000;
	localparam logic [31:0] HEAD_OFFSET  = 32'h4000_8000;
	localparam int          MAX_STEPS    = 24;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'h20000000;
			5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;
			5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;
			5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	function automatic logic signed [19:0] sat20(input logic signed [23:0] v);
		logic signed [19:0] r;
		if (v > 24'sd524287)
			r = 20'sh7FFFF;
		else if (v < -24'sd524288)
			r = 20'sh80000;
		else
			r = v[19:0];
		return r;
	endfunction

endpackage

// File: src/diff_drive_pose_and_sensor_points_top.sv
// Pose integrator for a two-wheeled robot. Each input word is either a time tick (wheel
// direction bits, PWM duties, elapsed time) or a pose load; each answers with one output
// word holding the new pose and the floor-grid pixels of the four body corners. All
// arithmetic runs through one 34x34 multiplier and one CORDIC stage used one iteration
// per cycle, plus a one-bit-per-cycle divider for the pixel scaling, so the block takes
// one word at a time. A time tick makes up to three CORDIC passes, a load makes one, and
// each word then makes up to eight pixel divisions. s_tready is high only between words;
// a finished word waits in the output register, and the next word is still taken but holds
// in ST_OUT until that register is free. Configuration writes are always taken and should
// be made while idle.
module diff_drive_pose_and_sensor_points_top #(
	parameter int SENSOR_GRID  = 512,
	parameter int CORDIC_STEPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// time_step[15:0], dir_bits[19:16], duty_left[27:20], duty_right[35:28],
	// load_x[55:36], load_y[75:56], load_heading[91:76], zero pad[95:92]
	input  logic [95:0]  s_tdata,
	// req_type[0]
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_x[19:0], out_y[39:20], out_heading[55:40], fl_px[64:56], fl_py[73:65],
	// fr_px[82:74], fr_py[91:83], bl_px[100:92], bl_py[109:101], br_px[118:110],
	// br_py[127:119]
	output logic [127:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [17:0]  cfg_data
);

	localparam int NSTEP = (CORDIC_STEPS > ddp_pkg::MAX_STEPS) ? ddp_pkg::MAX_STEPS : CORDIC_STEPS;
	localparam int QW    = $clog2(SENSOR_GRID);
	localparam int NW    = 27 + QW;
	localparam int CW    = $clog2(QW + 1);
	localparam logic [8:0] GMAX = 9'(SENSOR_GRID - 1);

	ddp_pkg::state_t state_q;

	logic [15:0]        half_track_q, half_length_q, speed_per_duty_q;
	logic [17:0]        arena_half_width_q;
	logic signed [19:0] pos_x_q, pos_y_q;
	logic [15:0]        heading_q;
	logic [15:0]        tau_q;
	logic [3:0]         dir_q;
	logic [7:0]         duty_l_q, duty_r_q;
	logic [3:0]         k_q;
	logic signed [67:0] prod_q;
	logic [31:0]        t_q;
	logic signed [28:0] d1_q, d2_q;
	logic signed [33:0] c_q, s_q;
	logic signed [31:0] res_q [6];
	logic signed [39:0] cx_q, cy_q;
	logic signed [33:0] cz_q;
	logic [4:0]         it_q;
	logic               vec_q, flip_q, ph_q;
	logic [2:0]         j_q;
	logic [26:0]        rem_q;
	logic [QW-1:0]      lo_q;
	logic [CW-1:0]      cnt_q;
	logic [8:0]         pix_q [8];
	logic               m_tvalid_q;
	logic [127:0]       m_tdata_q;

	assign s_tready  = (state_q == ddp_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// multiplier operands
	logic signed [33:0] hw34, hl34, opa, opb;
	assign hw34 = $signed({10'd0, half_track_q, 8'd0});
	assign hl34 = $signed({10'd0, half_length_q, 8'd0});

	always_comb begin
		case (k_q)
			ddp_pkg::MS_TAU_SPD: begin
				opa = $signed({18'd0, tau_q});
				opb = $signed({18'd0, speed_per_duty_q});
			end
			ddp_pkg::MS_DUTY_L: begin
				opa = $signed({2'd0, t_q});
				opb = $signed({26'd0, duty_l_q});
			end
			ddp_pkg::MS_DUTY_R: begin
				opa = $signed({2'd0, t_q});
				opb = $signed({26'd0, duty_r_q});
			end
			ddp_pkg::MS_HW_S, ddp_pkg::MS_SX: begin
				opa = hw34;
				opb = s_q;
			end
			ddp_pkg::MS_HW_C, ddp_pkg::MS_SY: begin
				opa = hw34;
				opb = c_q;
			end
			ddp_pkg::MS_D1_C: begin
				opa = 34'(d1_q);
				opb = c_q;
			end
			ddp_pkg::MS_D1_S: begin
				opa = 34'(d1_q);
				opb = s_q;
			end
			ddp_pkg::MS_D2_C: begin
				opa = 34'(d2_q);
				opb = c_q;
			end
			ddp_pkg::MS_D2_S: begin
				opa = 34'(d2_q);
				opb = s_q;
			end
			ddp_pkg::MS_FX: begin
				opa = hl34;
				opb = c_q;
			end
			ddp_pkg::MS_FY: begin
				opa = hl34;
				opb = s_q;
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	// write-back of a product
	logic [27:0]        mag;
	logic               w_fwd, w_back;
	logic signed [28:0] wheel_d;
	logic signed [31:0] prod_s30;
	logic [2:0]         ridx;

	always_comb begin
		mag      = prod_q[39:12];
		prod_s30 = 32'(prod_q >>> 30);
		if (k_q == ddp_pkg::MS_DUTY_L) begin
			w_fwd  = dir_q[1];
			w_back = dir_q[0];
		end else begin
			w_fwd  = dir_q[3];
			w_back = dir_q[2];
		end
		if (w_fwd && !w_back)
			wheel_d = $signed({1'b0, mag});
		else if (w_back && !w_fwd)
			wheel_d = -$signed({1'b0, mag});
		else
			wheel_d = '0;
		if (k_q >= ddp_pkg::MS_SX)
			ridx = 3'(k_q - ddp_pkg::MS_SX);
		else
			ridx = 3'(k_q - ddp_pkg::MS_HW_S);
	end

	// wheel points and new centre
	logic signed [31:0] xw, yw, x1, y1, x2, y2;
	logic signed [32:0] sum_x, sum_y, dx, dy;
	logic signed [39:0] vx, vy;

	always_comb begin
		xw    = {{4{pos_x_q[19]}}, pos_x_q, 8'd0};
		yw    = {{4{pos_y_q[19]}}, pos_y_q, 8'd0};
		x1    = xw - res_q[0] + res_q[2];
		y1    = yw + res_q[1] + res_q[3];
		x2    = xw + res_q[0] + res_q[4];
		y2    = yw - res_q[1] + res_q[5];
		sum_x = 33'(x1) + 33'(x2);
		sum_y = 33'(y1) + 33'(y2);
		dx    = 33'(x2) - 33'(x1);
		dy    = 33'(y2) - 33'(y1);
		vx    = 40'(dx) <<< 6;
		vy    = 40'(dy) <<< 6;
	end

	// CORDIC stage
	logic signed [39:0] shx, shy;
	logic signed [33:0] at;
	logic               rot_pos;
	logic [31:0]        ang, ang2;
	logic               qflip;
	logic [31:0]        hsum;

	always_comb begin
		shx     = cx_q >>> it_q;
		shy     = cy_q >>> it_q;
		at      = $signed({2'b00, ddp_pkg::atan_turn(it_q)});
		rot_pos = vec_q ? cy_q[39] : ~cz_q[33];
		ang     = {heading_q, 16'd0};
		qflip   = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
		ang2    = qflip ? (ang - ddp_pkg::TURN_HALF) : ang;
		hsum    = 32'(cz_q) + ddp_pkg::HEAD_OFFSET;
	end

	// corner point and pixel scaling
	logic signed [33:0] base, side, fr, p, q;
	logic [26:0]        dv;
	logic [NW-1:0]      num;
	logic [27:0]        rem2;
	logic               ge;

	always_comb begin
		base = j_q[0] ? 34'(yw) : 34'(xw);
		side = j_q[0] ? -34'(res_q[1]) : 34'(res_q[0]);
		fr   = j_q[0] ? 34'(res_q[3]) : 34'(res_q[2]);
		p    = base + (j_q[1] ? side : -side) + (j_q[2] ? -fr : fr);
		q    = p + $signed({8'd0, arena_half_width_q, 8'd0});
		dv   = {arena_half_width_q, 9'd0};
		num  = NW'(q[26:0]) * NW'(SENSOR_GRID);
		rem2 = {rem_q, lo_q[QW-1]};
		ge   = (rem2 >= {1'b0, dv});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= ddp_pkg::ST_IDLE;
			half_track_q       <= 16'd5243;
			half_length_q      <= 16'd6554;
			speed_per_duty_q   <= 16'd1049;
			arena_half_width_q <= 18'd45875;
			pos_x_q            <= '0;
			pos_y_q            <= '0;
			heading_q          <= '0;
			m_tvalid_q         <= 1'b0;
			m_tdata_q          <= '0;
			tau_q              <= '0;
			dir_q              <= '0;
			duty_l_q           <= '0;
			duty_r_q           <= '0;
			k_q                <= '0;
			prod_q             <= '0;
			t_q                <= '0;
			d1_q               <= '0;
			d2_q               <= '0;
			c_q                <= '0;
			s_q                <= '0;
			for (int i = 0; i < 6; i++)
				res_q[i] <= '0;
			cx_q               <= '0;
			cy_q               <= '0;
			cz_q               <= '0;
			it_q               <= '0;
			vec_q              <= 1'b0;
			flip_q             <= 1'b0;
			ph_q               <= 1'b0;
			j_q                <= '0;
			rem_q              <= '0;
			lo_q               <= '0;
			cnt_q              <= '0;
			for (int i = 0; i < 8; i++)
				pix_q[i] <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					ddp_pkg::REG_HALF_TRACK:  half_track_q       <= cfg_data[15:0];
					ddp_pkg::REG_HALF_LENGTH: half_length_q      <= cfg_data[15:0];
					ddp_pkg::REG_SPEED:       speed_per_duty_q   <= cfg_data[15:0];
					ddp_pkg::REG_ARENA:       arena_half_width_q <= cfg_data;
					default: ;
				endcase
			end

			// drop the output word once taken, unless a new one replaces it
			if (m_tvalid_q && m_tready && (state_q != ddp_pkg::ST_OUT))
				m_tvalid_q <= 1'b0;

			case (state_q)
				ddp_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						tau_q    <= s_tdata[15:0];
						dir_q    <= s_tdata[19:16];
						duty_l_q <= s_tdata[27:20];
						duty_r_q <= s_tdata[35:28];
						if (s_tuser[0]) begin
							pos_x_q   <= $signed(s_tdata[55:36]);
							pos_y_q   <= $signed(s_tdata[75:56]);
							heading_q <= s_tdata[91:76];
							ph_q      <= 1'b1;
							state_q   <= ddp_pkg::ST_SCI;
						end else begin
							ph_q    <= 1'b0;
							k_q     <= ddp_pkg::MS_TAU_SPD;
							state_q <= ddp_pkg::ST_MUL;
						end
					end
				end
				ddp_pkg::ST_MUL: begin
					prod_q  <= opa * opb;
					state_q <= ddp_pkg::ST_WB;
				end
				ddp_pkg::ST_WB: begin
					case (k_q)
						ddp_pkg::MS_TAU_SPD: t_q  <= prod_q[31:0];
						ddp_pkg::MS_DUTY_L:  d1_q <= wheel_d;
						ddp_pkg::MS_DUTY_R:  d2_q <= wheel_d;
						default:             res_q[ridx] <= prod_s30;
					endcase
					if (k_q == ddp_pkg::MS_DUTY_R) begin
						state_q <= ddp_pkg::ST_SCI;
					end else if (k_q == ddp_pkg::MS_D2_S) begin
						state_q <= ddp_pkg::ST_CENT;
					end else if (k_q == ddp_pkg::MS_FY) begin
						j_q     <= '0;
						state_q <= ddp_pkg::ST_PXI;
					end else begin
						k_q     <= k_q + 4'd1;
						state_q <= ddp_pkg::ST_MUL;
					end
				end
				ddp_pkg::ST_SCI: begin
					// fold the left half-plane onto the right and flip the result
					flip_q  <= qflip;
					cz_q    <= 34'($signed(ang2));
					cx_q    <= $signed({8'd0, ddp_pkg::CORDIC_GAIN});
					cy_q    <= '0;
					vec_q   <= 1'b0;
					it_q    <= '0;
					state_q <= ddp_pkg::ST_ROT;
				end
				ddp_pkg::ST_ROT: begin
					if (rot_pos) begin
						cx_q <= cx_q - shy;
						cy_q <= cy_q + shx;
						cz_q <= cz_q - at;
					end else begin
						cx_q <= cx_q + shy;
						cy_q <= cy_q - shx;
						cz_q <= cz_q + at;
					end
					it_q <= it_q + 5'd1;
					if (it_q == 5'(NSTEP - 1))
						state_q <= vec_q ? ddp_pkg::ST_VECD : ddp_pkg::ST_SCD;
				end
				ddp_pkg::ST_SCD: begin
					c_q     <= flip_q ? -34'(cx_q) : 34'(cx_q);
					s_q     <= flip_q ? -34'(cy_q) : 34'(cy_q);
					k_q     <= ph_q ? ddp_pkg::MS_SX : ddp_pkg::MS_HW_S;
					state_q <= ddp_pkg::ST_MUL;
				end
				ddp_pkg::ST_CENT: begin
					pos_x_q <= ddp_pkg::sat20(24'(sum_x >>> 9));
					pos_y_q <= ddp_pkg::sat20(24'(sum_y >>> 9));
					ph_q    <= 1'b1;
					if (dx == '0) begin
						heading_q <= dy[32] ? 16'h0000 : 16'h8000;
						state_q   <= ddp_pkg::ST_SCI;
					end else begin
						// vectoring pass: bring the wheel vector into the right half-plane
						if (dx[32]) begin
							cx_q <= -vx;
							cy_q <= -vy;
							cz_q <= $signed({2'b00, ddp_pkg::TURN_HALF});
						end else begin
							cx_q <= vx;
							cy_q <= vy;
							cz_q <= '0;
						end
						vec_q   <= 1'b1;
						it_q    <= '0;
						state_q <= ddp_pkg::ST_ROT;
					end
				end
				ddp_pkg::ST_VECD: begin
					heading_q <= hsum[31:16];
					state_q   <= ddp_pkg::ST_SCI;
				end
				ddp_pkg::ST_PXI: begin
					if (q <= 34'sd0) begin
						pix_q[j_q] <= '0;
						state_q    <= (j_q == 3'd7) ? ddp_pkg::ST_OUT : ddp_pkg::ST_PXI;
						j_q        <= j_q + 3'd1;
					end else if (q >= $signed({7'd0, dv})) begin
						pix_q[j_q] <= GMAX;
						state_q    <= (j_q == 3'd7) ? ddp_pkg::ST_OUT : ddp_pkg::ST_PXI;
						j_q        <= j_q + 3'd1;
					end else begin
						rem_q   <= num[NW-1:QW];
						lo_q    <= num[QW-1:0];
						cnt_q   <= '0;
						state_q <= ddp_pkg::ST_PXD;
					end
				end
				ddp_pkg::ST_PXD: begin
					rem_q <= ge ? 27'(rem2 - {1'b0, dv}) : 27'(rem2);
					lo_q  <= {lo_q[QW-2:0], ge};
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(QW - 1)) begin
						pix_q[j_q] <= 9'({lo_q[QW-2:0], ge});
						state_q    <= (j_q == 3'd7) ? ddp_pkg::ST_OUT : ddp_pkg::ST_PXI;
						j_q        <= j_q + 3'd1;
					end
				end
				ddp_pkg::ST_OUT: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {pix_q[7], pix_q[6], pix_q[5], pix_q[4], pix_q[3],
							pix_q[2], pix_q[1], pix_q[0], heading_q, pos_y_q, pos_x_q};
						state_q    <= ddp_pkg::ST_IDLE;
					end
				end
				default: state_q <= ddp_pkg::ST_IDLE;
			endcase
		end
	end

endmodule
